// ===== hw/rtl/mlpq_pkg.sv =====
// Shared constants and codes for the multilevel priority FIFO.
`timescale 1ns / 1ps
`default_nettype none

package mlpq_pkg;

    localparam int NUM_LEVELS_DEF   = 8;
    localparam int LEVEL_DEPTH_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int REQ_W     = 2;
    localparam int PRIO_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int OUT_LVL_W = 3;
    localparam int CFG_W     = 4;

    localparam logic [CFG_W-1:0] LEVELS_IN_USE_RST = CFG_W'(8);

    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/multilevel_priority_fifo_top.sv =====
// Multilevel priority FIFO: per-level ring buffers in one shared entry memory.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_req_type, s_priority_req, s_payload
//  m_      | out       | m_valid / m_ready  | m_status, m_out_payload, m_out_level
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data (levels_in_use)
//
// Each request passes from the pending stage to the output register. The level
// state is resolved and the entry memory is read or written in the accept cycle;
// the registered read data waits with the pending stage and moves to the output
// register when m_ is free. One request is accepted per cycle while results drain.
// Reset (aresetn low, synchronous) empties every level and sets levels_in_use to 8;
// memory contents are not cleared. A stalled m_ holds one result in the output
// register and one in the pending stage, then drops s_ready.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_priority_fifo_top #(
    parameter int NUM_LEVELS   = mlpq_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH  = mlpq_pkg::LEVEL_DEPTH_DEF,
    parameter int PAYLOAD_BITS = mlpq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_wr_en,
    input  wire logic [mlpq_pkg::CFG_W-1:0]     cfg_wr_data,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [mlpq_pkg::REQ_W-1:0]     s_req_type,
    input  wire logic [mlpq_pkg::PRIO_W-1:0]    s_priority_req,
    input  wire logic [PAYLOAD_BITS-1:0]        s_payload,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [mlpq_pkg::STATUS_W-1:0]       m_status,
    output logic [PAYLOAD_BITS-1:0]             m_out_payload,
    output logic [mlpq_pkg::OUT_LVL_W-1:0]      m_out_level
);

    localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SLOT_W    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
    localparam int SUM_W     = SLOT_W + 1;
    localparam int ADDR_W    = LVL_W + SLOT_W;
    localparam int MEM_DEPTH = NUM_LEVELS * (2 ** SLOT_W);

    // Configuration
    logic [mlpq_pkg::CFG_W-1:0] levels_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_in_use_reg <= mlpq_pkg::LEVELS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            levels_in_use_reg <= cfg_wr_data;
        end
    end

    // Per-level ring state
    logic [SLOT_W-1:0] head_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]  count_reg [NUM_LEVELS];

    // Entry memory
    logic [PAYLOAD_BITS-1:0] entry_mem [MEM_DEPTH];
    logic [PAYLOAD_BITS-1:0] rd_data_reg;

    // Pending stage and output register
    logic                             p_valid_reg, p_valid_next;
    logic                             p_hit_reg;
    logic [mlpq_pkg::STATUS_W-1:0]    p_status_reg;
    logic [mlpq_pkg::OUT_LVL_W-1:0]   p_level_reg;

    logic                             m_valid_reg, m_valid_next;
    logic [mlpq_pkg::STATUS_W-1:0]    m_status_reg;
    logic [PAYLOAD_BITS-1:0]          m_payload_reg;
    logic [mlpq_pkg::OUT_LVL_W-1:0]   m_level_reg;

    logic accept;
    logic move;

    // Level selection
    logic [NUM_LEVELS-1:0] ready_lvls;
    logic                  found;
    logic [LVL_W-1:0]      top_lvl;
    logic                  prio_ok;
    logic [LVL_W-1:0]      prio_lvl;
    logic [LVL_W-1:0]      sel_lvl;
    logic [SLOT_W-1:0]     sel_head;
    logic [CNT_W-1:0]      sel_count;
    logic                  sel_full;
    logic [SUM_W-1:0]      tail_sum;
    logic [SLOT_W-1:0]     tail_slot;
    logic [SLOT_W-1:0]     head_adv;

    // Per-request decode
    logic                             is_enq;
    logic                             mem_we;
    logic                             mem_re;
    logic                             cnt_inc;
    logic                             cnt_dec;
    logic [ADDR_W-1:0]                mem_addr;
    logic [mlpq_pkg::STATUS_W-1:0]    req_status;
    logic                             req_hit;

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            ready_lvls[l] = (count_reg[l] != '0) && (int'(levels_in_use_reg) > l);
        end
    end

    // Highest ready level wins
    always_comb begin
        found   = 1'b0;
        top_lvl = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (ready_lvls[l]) begin
                found   = 1'b1;
                top_lvl = LVL_W'(l);
            end
        end
    end

    assign prio_ok  = ({1'b0, s_priority_req} < levels_in_use_reg)
                      && (int'(s_priority_req) < NUM_LEVELS);
    assign prio_lvl = LVL_W'(s_priority_req);
    assign is_enq   = (s_req_type == mlpq_pkg::REQ_ENQ);
    assign sel_lvl  = is_enq ? prio_lvl : top_lvl;

    assign sel_head  = head_reg[sel_lvl];
    assign sel_count = count_reg[sel_lvl];
    assign sel_full  = (sel_count == CNT_W'(LEVEL_DEPTH));

    assign tail_sum  = SUM_W'(sel_head) + SUM_W'(sel_count);
    assign tail_slot = (tail_sum >= SUM_W'(LEVEL_DEPTH))
                       ? SLOT_W'(tail_sum - SUM_W'(LEVEL_DEPTH))
                       : SLOT_W'(tail_sum);
    assign head_adv  = (sel_head == SLOT_W'(LEVEL_DEPTH - 1)) ? '0 : sel_head + 1'b1;

    assign mem_addr = {sel_lvl, (is_enq ? tail_slot : sel_head)};

    always_comb begin
        req_status = mlpq_pkg::ST_OK;
        req_hit    = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        unique case (s_req_type) inside
            mlpq_pkg::REQ_ENQ: begin
                if (!prio_ok) begin
                    req_status = mlpq_pkg::ST_RANGE;
                end else if (sel_full) begin
                    req_status = mlpq_pkg::ST_FULL;
                end else begin
                    cnt_inc = 1'b1;
                end
            end
            mlpq_pkg::REQ_DEQ, mlpq_pkg::REQ_PEEK: begin
                if (!found) begin
                    req_status = mlpq_pkg::ST_EMPTY;
                end else begin
                    req_hit = 1'b1;
                    cnt_dec = (s_req_type == mlpq_pkg::REQ_DEQ);
                end
            end
            default: begin
                req_status = mlpq_pkg::ST_OK;
            end
        endcase
    end

    // Handshake
    assign move    = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p_valid_reg || move;
    assign accept  = s_valid && s_ready;
    assign mem_we  = accept && cnt_inc;
    assign mem_re  = accept && req_hit;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_addr] <= s_payload;
        end
        if (mem_re) begin
            rd_data_reg <= entry_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end else if (accept) begin
            if (cnt_inc) begin
                count_reg[sel_lvl] <= sel_count + 1'b1;
            end
            if (cnt_dec) begin
                count_reg[sel_lvl] <= sel_count - 1'b1;
                head_reg[sel_lvl]  <= head_adv;
            end
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (move) begin
            p_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_hit_reg    <= req_hit;
            p_status_reg <= req_status;
            p_level_reg  <= req_hit ? mlpq_pkg::OUT_LVL_W'(top_lvl) : '0;
        end
        if (move) begin
            m_status_reg  <= p_status_reg;
            m_payload_reg <= p_hit_reg ? rd_data_reg : '0;
            m_level_reg   <= p_level_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_payload = m_payload_reg;
    assign m_out_level   = m_level_reg;

endmodule

`default_nettype wire
